// ===== sv/arpc_pkg.sv =====
// Shared types and constants for the audio record/playback controller.
// No dependencies; imported by arpc_conv and the top level.
`default_nettype none

package arpc_pkg;

  localparam int GAIN_W   = 12;
  localparam int OFFSET_W = 13;
  localparam int LIMIT_W  = 15;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [GAIN_W-1:0]   GAIN_RST   = 12'd512;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 13'd4095;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 15'd16000;

  typedef enum logic [1:0] {
    REG_GAIN   = 2'd0,
    REG_OFFSET = 2'd1,
    REG_LIMIT  = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_REC  = 2'd1,
    MODE_PLAY = 2'd2,
    MODE_RSVD = 2'd3
  } mode_t;

endpackage

`default_nettype wire

// ===== sv/arpc_store.sv =====
// Sample store: single write port, single read port with registered read data.
// No package dependencies.
`default_nettype none

module arpc_store #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14,
  parameter int DW    = 12
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== sv/arpc_conv.sv =====
// Sample-to-PWM conversion unit: offset removal, Q8 gain, clamp, then a
// reciprocal multiply that scales to the PWM range. Uses arpc_pkg.
`default_nettype none

module arpc_conv
  import arpc_pkg::*;
#(
  parameter int SAMPLE_BITS = 12,
  parameter int LEVEL_BITS  = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic [GAIN_W-1:0]      gain,
  input  wire logic [OFFSET_W-1:0]    offset,
  output logic                        done,
  output logic [LEVEL_BITS-1:0]       level
);

  localparam int DW     = ((SAMPLE_BITS + 1 > OFFSET_W) ? SAMPLE_BITS + 1 : OFFSET_W) + 1;
  localparam int PW     = DW + GAIN_W + 1;
  localparam int XW     = SAMPLE_BITS + 1;
  localparam int FS_VAL = 2 * ((1 << SAMPLE_BITS) - 1);
  localparam int LMAX   = (1 << LEVEL_BITS) - 1;
  // x * LMAX / FS as x * RECIP >> SH; exact for x in [0, FS] since FS^2 < 2^SH
  localparam int SH     = 2 * XW;
  localparam int RW     = LEVEL_BITS + SH - XW + 2;
  localparam int SW     = XW + RW;
  localparam longint RECIP = ((longint'(LMAX) << SH) + longint'(FS_VAL) - 1)
                           / longint'(FS_VAL);
  localparam logic [RW-1:0] RECIP_V = RW'(RECIP);

  typedef enum logic [3:0] {
    C_IDLE  = 4'b0001,
    C_MUL   = 4'b0010,
    C_CLAMP = 4'b0100,
    C_SCALE = 4'b1000
  } conv_state_t;

  conv_state_t             state_r, state_nxt;
  logic signed [DW-1:0]    diff_r, diff_nxt;
  logic signed [PW-1:0]    prod_r, prod_nxt;
  logic [XW-1:0]           xc_r, xc_nxt;
  logic [LEVEL_BITS-1:0]   quo_r, quo_nxt;
  logic                    done_r, done_nxt;

  logic signed [PW-1:0]    prod_sh;
  logic signed [PW:0]      x_sum;
  logic [SW-1:0]           scale_prod;

  always_comb begin
    prod_sh    = prod_r >>> 8;
    x_sum      = $signed({prod_sh[PW-1], prod_sh})
               + $signed({{(PW + 1 - OFFSET_W){1'b0}}, offset});
    scale_prod = {{RW{1'b0}}, xc_r} * {{XW{1'b0}}, RECIP_V};
  end

  always_comb begin
    state_nxt = state_r;
    diff_nxt  = diff_r;
    prod_nxt  = prod_r;
    xc_nxt    = xc_r;
    quo_nxt   = quo_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          diff_nxt  = $signed({{(DW - SAMPLE_BITS - 1){1'b0}}, sample, 1'b0})
                    - $signed({{(DW - OFFSET_W){1'b0}}, offset});
          state_nxt = C_MUL;
        end
      end
      C_MUL: begin
        prod_nxt  = diff_r * $signed({1'b0, gain});
        state_nxt = C_CLAMP;
      end
      C_CLAMP: begin
        if (x_sum < 0) begin
          xc_nxt = '0;
        end else if (x_sum > $signed((PW + 1)'(FS_VAL))) begin
          xc_nxt = XW'(FS_VAL);
        end else begin
          xc_nxt = x_sum[XW-1:0];
        end
        state_nxt = C_SCALE;
      end
      C_SCALE: begin
        quo_nxt   = scale_prod[SH +: LEVEL_BITS];
        done_nxt  = 1'b1;
        state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    prod_r <= prod_nxt;
    xc_r   <= xc_nxt;
    quo_r  <= quo_nxt;
  end

  assign done  = done_r;
  assign level = quo_r;

endmodule

`default_nettype wire

// ===== sv/audio_record_playback_controller.sv =====
// Top level of the audio record/playback controller: APB register file,
// mode sequencer, sample store and conversion unit. Uses arpc_pkg,
// arpc_store and arpc_conv.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   sample_due, buttons, adc_sample
//   out_     output     out_valid / out_ready pwm_level, lamps, mode
//   cfg      input      APB psel/penable      gain, dc offset, record limit
//
// A poll runs the evaluate and completion states; a playback tick also runs the
// store read and the gain, clamp and scale steps in the conversion unit.
// in_ready is high only in the idle state; a held result does not block it.
// out_ready low with a result held keeps the next one in the completion state.
// Reset clears the mode, counters, level and registers; the store is not cleared.
`default_nettype none

module audio_record_playback_controller
  import arpc_pkg::*;
#(
  parameter int STORE_DEPTH = 16384,
  parameter int SAMPLE_BITS = 12,
  parameter int LEVEL_BITS  = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_sample_due,
  input  wire logic                   in_record_button_down,
  input  wire logic                   in_play_button_down,
  input  wire logic [SAMPLE_BITS-1:0] in_adc_sample,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [LEVEL_BITS-1:0]       out_pwm_level,
  output logic                        out_record_lamp,
  output logic                        out_play_lamp,
  output logic [1:0]                  out_mode,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [PADDR_W-1:0]     paddr,
  input  wire logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]          prdata,
  output logic                        pready
);

  localparam int AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_READ = 5'b00100,
    S_CONV = 5'b01000,
    S_DONE = 5'b10000
  } ctl_state_t;

  // configuration
  logic [GAIN_W-1:0]   gain_r;
  logic [OFFSET_W-1:0] offset_r;
  logic [LIMIT_W-1:0]  limit_r;
  reg_idx_t            reg_sel;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RST;
      offset_r <= OFFSET_RST;
      limit_r  <= LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_GAIN:   gain_r   <= pwdata[GAIN_W-1:0];
        REG_OFFSET: offset_r <= pwdata[OFFSET_W-1:0];
        REG_LIMIT:  limit_r  <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_GAIN:   prdata = PDATA_W'(gain_r);
      REG_OFFSET: prdata = PDATA_W'(offset_r);
      REG_LIMIT:  prdata = PDATA_W'(limit_r);
      default:    prdata = '0;
    endcase
  end

  // sequencer state
  ctl_state_t             state_r, state_nxt;
  mode_t                  mode_r, mode_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       pos_r, pos_nxt;
  logic [LEVEL_BITS-1:0]  level_r, level_nxt;
  logic                   tick_r, rec_r, play_r;
  logic [SAMPLE_BITS-1:0] adc_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [LEVEL_BITS-1:0]  out_level_r;
  mode_t                  out_mode_r;

  logic [CNT_W-1:0]       lim;
  logic                   in_fire;
  logic                   out_free;
  logic                   wr_en, rd_en, conv_start, conv_done;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [LEVEL_BITS-1:0]  conv_level;

  assign lim = ({{(32 - LIMIT_W){1'b0}}, limit_r} > 32'(STORE_DEPTH)) ?
               CNT_W'(STORE_DEPTH) : CNT_W'(limit_r);

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid & in_ready;
  assign out_free   = ~out_valid_r | out_ready;
  assign conv_start = (state_r == S_READ);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    level_nxt     = level_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_DONE;
        unique case (mode_r)
          MODE_REC: begin
            if (tick_r) begin
              if (count_r < lim) begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
              end else begin
                mode_nxt = MODE_IDLE;
              end
            end
            if (!rec_r) begin
              mode_nxt = MODE_IDLE;
            end
          end
          MODE_PLAY: begin
            if (tick_r) begin
              if (pos_r < count_r) begin
                rd_en     = 1'b1;
                pos_nxt   = pos_r + 1'b1;
                state_nxt = S_READ;
              end else begin
                level_nxt = '0;
                mode_nxt  = MODE_IDLE;
              end
            end
          end
          default: begin
            mode_nxt = MODE_IDLE;
            if (rec_r) begin
              mode_nxt  = MODE_REC;
              count_nxt = '0;
            end else if (play_r && count_r != '0) begin
              mode_nxt = MODE_PLAY;
              pos_nxt  = '0;
            end
          end
        endcase
      end
      S_READ: state_nxt = S_CONV;
      S_CONV: begin
        if (conv_done) begin
          level_nxt = conv_level;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_IDLE;
      count_r     <= '0;
      pos_r       <= '0;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tick_r <= in_sample_due;
      rec_r  <= in_record_button_down;
      play_r <= in_play_button_down;
      adc_r  <= in_adc_sample;
    end
    if (state_r == S_DONE && out_free) begin
      out_level_r <= level_r;
      out_mode_r  <= mode_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pwm_level   = out_level_r;
  assign out_mode        = out_mode_r;
  assign out_record_lamp = (out_mode_r == MODE_REC);
  assign out_play_lamp   = (out_mode_r == MODE_PLAY);

  arpc_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW),
    .DW    (SAMPLE_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (adc_r),
    .rd_en   (rd_en),
    .rd_addr (pos_r[AW-1:0]),
    .rd_data (rd_data)
  );

  arpc_conv #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .LEVEL_BITS  (LEVEL_BITS)
  ) u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (conv_start),
    .sample (rd_data),
    .gain   (gain_r),
    .offset (offset_r),
    .done   (conv_done),
    .level  (conv_level)
  );

endmodule

`default_nettype wire
